/* src/hmqp_pkg.sv */
// ----------------------------------------------------------------------------
// hmqp_pkg: shared types and constants for the quadratic-probe multimap
// slot geometry, field widths, opcodes, status and tag codes, and the
// command and status bundles between controller and datapath
// ----------------------------------------------------------------------------
package hmqp_pkg;

   // table geometry (slot count is a power of two, so key mod slots is a mask)
   localparam int SLOTS    = 64;
   localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // item field widths
   localparam int OP_W     = 2;
   localparam int KEY_W    = 31;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int TAG_W    = 2;

   // probe step coefficients: offset of probe i is STEP_LINEAR*i + STEP_SQUARE*i*i
   localparam int STEP_LINEAR = 1;
   localparam int STEP_SQUARE = 5;
   // distance from probe i to i+1 is DELTA_INIT + DELTA_INC*i
   localparam int DELTA_INIT  = (STEP_LINEAR + STEP_SQUARE) % SLOTS;
   localparam int DELTA_INC   = (2 * STEP_SQUARE) % SLOTS;

   // opcodes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   // slot tags
   localparam logic [TAG_W-1:0] TAG_EMPTY   = 2'd0;
   localparam logic [TAG_W-1:0] TAG_LIVE    = 2'd1;
   localparam logic [TAG_W-1:0] TAG_DELETED = 2'd2;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_type;

   localparam int SLOT_BITS = $bits(slot_type);

   // controller to datapath
   typedef struct packed {
      logic             load;        // capture an accepted item, start the probe
      logic             rd;          // read the current slot
      logic             step;        // advance to the next probe
      logic             wr_en;       // write the current slot
      logic [TAG_W-1:0] wr_tag;
      logic             cnt_inc;
      logic             cnt_dec;
      logic             set_ok;
      logic             set_full;
      logic             pend_emit;   // send the held search match, not last
      logic             pend_load;   // hold the match just read
      logic             final_push;  // send the closing result of the item
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [TAG_W-1:0] tag;
      logic             key_eq;
      logic             value_eq;
      logic             last_probe;
      logic             out_free;
      logic             have_pend;
   } dp_sts_type;

   // modular add of two slot indexes, both below SLOTS
   function automatic logic [SLOT_W-1:0] mod_add(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
      logic [SLOT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (SLOT_W+1)'(SLOTS)) begin
         sum = sum - (SLOT_W+1)'(SLOTS);
      end
      return sum[SLOT_W-1:0];
   endfunction

endpackage

/* src/hmqp_req_if.sv */
// ----------------------------------------------------------------------------
// hmqp_req_if: request channel
// valid/ready handshake carrying one operation item
// ----------------------------------------------------------------------------
interface hmqp_req_if import hmqp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [KEY_W-1:0]   key;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output op, output key, output value, input ready);
   modport sink   (input valid, input op, input key, input value, output ready);
endinterface

/* src/hmqp_rsp_if.sv */
// ----------------------------------------------------------------------------
// hmqp_rsp_if: response channel
// valid/ready handshake carrying one result item
// ----------------------------------------------------------------------------
interface hmqp_rsp_if import hmqp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  found_value;
   logic [STATUS_W-1:0] status;
   logic                last;
   logic [COUNT_W-1:0]  entry_total;

   modport source (output valid, output found_value, output status, output last,
                   output entry_total, input ready);
   modport sink   (input valid, input found_value, input status, input last,
                   input entry_total, output ready);
endinterface

/* src/hmqp_ram.sv */
// ----------------------------------------------------------------------------
// hmqp_ram: generic single-write, single-read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module hmqp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/hmqp_datapath.sv */
// ----------------------------------------------------------------------------
// hmqp_datapath: probe datapath of the multimap
// probe address generation, slot memory, tag valid bits, entry count,
// held search match and the result output register
// ----------------------------------------------------------------------------
module hmqp_datapath import hmqp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ctl_cmd_type        cmd,
   output dp_sts_type         sts,
   input  logic [OP_W-1:0]    req_op,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [VALUE_W-1:0] req_value,
   hmqp_rsp_if.source         rsp
);

   // captured item
   logic [OP_W-1:0]     op_ff,    op_in;
   logic [KEY_W-1:0]    key_ff,   key_in;
   logic [VALUE_W-1:0]  value_ff, value_in;

   // probe walk
   logic [SLOT_W-1:0]   idx_ff,   idx_in;
   logic [SLOT_W-1:0]   pos_ff,   pos_in;
   logic [SLOT_W-1:0]   delta_ff, delta_in;

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [STATUS_W-1:0] res_ff,   res_in;
   logic [VALUE_W-1:0]  pend_ff,  pend_in;
   logic                have_pend_ff, have_pend_in;
   logic [SLOTS-1:0]    tag_valid_ff, tag_valid_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0]  rsp_total_ff, rsp_total_in;

   slot_type            rd_slot;
   slot_type            wr_slot;
   logic [SLOT_BITS-1:0] rd_bits;
   logic                out_free;

   hmqp_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (pos_ff),
      .wr_data (wr_slot),
      .rd_en   (cmd.rd),
      .rd_addr (pos_ff),
      .rd_data (rd_bits)
   );

   assign rd_slot  = slot_type'(rd_bits);
   assign wr_slot  = '{tag: cmd.wr_tag, key: key_ff, value: value_ff};
   assign out_free = !rsp_valid_ff || rsp.ready;

   // status back to the controller
   always_comb begin
      sts.op         = op_ff;
      sts.tag        = tag_valid_ff[pos_ff] ? rd_slot.tag : TAG_EMPTY;
      sts.key_eq     = (rd_slot.key == key_ff);
      sts.value_eq   = (rd_slot.value == value_ff);
      sts.last_probe = (idx_ff == SLOT_W'(SLOTS - 1));
      sts.out_free   = out_free;
      sts.have_pend  = have_pend_ff;
   end

   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      delta_in     = delta_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      pend_in      = pend_ff;
      have_pend_in = have_pend_ff;
      tag_valid_in = tag_valid_ff;

      if (cmd.load) begin
         op_in        = req_op;
         key_in       = req_key;
         value_in     = req_value;
         idx_in       = '0;
         // search scans slots in index order, the others walk the probe path
         pos_in       = (req_op == OP_SEARCH) ? '0 : SLOT_W'(req_key % SLOTS);
         delta_in     = SLOT_W'(DELTA_INIT);
         res_in       = ST_NOT_FOUND;
         have_pend_in = 1'b0;
      end

      if (cmd.step) begin
         idx_in   = idx_ff + SLOT_W'(1);
         pos_in   = (op_ff == OP_SEARCH) ? pos_ff + SLOT_W'(1) : mod_add(pos_ff, delta_ff);
         delta_in = mod_add(delta_ff, SLOT_W'(DELTA_INC));
      end

      if (cmd.wr_en) begin
         tag_valid_in[pos_ff] = 1'b1;
      end
      if (cmd.cnt_inc) begin
         count_in = count_ff + COUNT_W'(1);
      end
      if (cmd.cnt_dec) begin
         count_in = count_ff - COUNT_W'(1);
      end
      if (cmd.set_ok) begin
         res_in = ST_OK;
      end
      if (cmd.set_full) begin
         res_in = ST_FULL;
      end
      if (cmd.pend_load) begin
         pend_in      = rd_slot.value;
         have_pend_in = 1'b1;
      end
   end

   // result output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_total_in  = rsp_total_ff;

      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.pend_emit) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = pend_ff;
         rsp_status_in = ST_OK;
         rsp_last_in   = 1'b0;
         rsp_total_in  = count_ff;
      end else if (cmd.final_push) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = have_pend_ff ? pend_ff : '0;
         rsp_status_in = have_pend_ff ? ST_OK : res_ff;
         rsp_last_in   = 1'b1;
         rsp_total_in  = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         have_pend_ff <= 1'b0;
         tag_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         have_pend_ff <= have_pend_in;
         tag_valid_ff <= tag_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      delta_ff      <= delta_in;
      res_ff        <= res_in;
      pend_ff       <= pend_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.found_value = rsp_value_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.last        = rsp_last_ff;
   assign rsp.entry_total = rsp_total_ff;

endmodule

/* src/hmqp_ctrl.sv */
// ----------------------------------------------------------------------------
// hmqp_ctrl: operation sequencer of the multimap
// accepts an item, walks the probe path or scan one slot per read/check
// pair, and orders the writes and results
// ----------------------------------------------------------------------------
module hmqp_ctrl import hmqp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_ready,
   input  dp_sts_type      sts,
   output ctl_cmd_type     cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EVAL = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       search_hit;

   assign search_hit = (sts.tag == TAG_LIVE) && sts.key_eq;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.wr_tag = TAG_LIVE;
      req_ready = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_op == OP_INSERT || req_op == OP_REMOVE ||
                           req_op == OP_SEARCH) ? S_READ : S_DONE;
            end
         end

         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_EVAL;
         end

         S_EVAL: begin
            unique case (sts.op)
               OP_INSERT: begin
                  if (sts.tag != TAG_LIVE) begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_tag  = TAG_LIVE;
                     cmd.cnt_inc = 1'b1;
                     cmd.set_ok  = 1'b1;
                     state_in    = S_DONE;
                  end else if (sts.last_probe) begin
                     cmd.set_full = 1'b1;
                     state_in     = S_DONE;
                  end else begin
                     cmd.step = 1'b1;
                     state_in = S_READ;
                  end
               end

               OP_REMOVE: begin
                  if (sts.tag == TAG_EMPTY) begin
                     state_in = S_DONE;
                  end else if (sts.tag == TAG_LIVE && sts.key_eq && sts.value_eq) begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_tag  = TAG_DELETED;
                     cmd.cnt_dec = 1'b1;
                     cmd.set_ok  = 1'b1;
                     state_in    = S_DONE;
                  end else if (sts.last_probe) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.step = 1'b1;
                     state_in = S_READ;
                  end
               end

               OP_SEARCH: begin
                  // a held match goes out only once the next one proves it is not last
                  if (!(search_hit && sts.have_pend && !sts.out_free)) begin
                     if (search_hit) begin
                        cmd.pend_load = 1'b1;
                        cmd.pend_emit = sts.have_pend;
                     end
                     if (sts.last_probe) begin
                        state_in = S_DONE;
                     end else begin
                        cmd.step = 1'b1;
                        state_in = S_READ;
                     end
                  end
               end

               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_DONE: begin
            if (sts.out_free) begin
               cmd.final_push = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/hash_multimap_quadratic_probe_top.sv */
// ----------------------------------------------------------------------------
// hash_multimap_quadratic_probe_top: open-addressing key/value multimap
// 64-slot table with quadratic probing, insert, remove and search-all
// ----------------------------------------------------------------------------
// usage
//   req_ch carries one item: op (insert, remove, search), key and value;
//   it is taken when valid and ready are both high
//   rsp_ch returns results: insert and remove give exactly one, search gives
//   one per matching slot in slot order (last set on the final one) or a
//   single not-found result; every result carries the live pair count
// operation
//   each probe is a slot memory read followed by a check; insert and remove
//   stop at the first slot that settles them or after the last probe, search
//   always scans all 64 slots; an item also passes an accept state and a
//   closing state
//   one item is worked on at a time; the next item is taken as soon as the
//   final result sits in the output register
// reset
//   synchronous, active high; every slot reads as empty and the count is zero
//   at once (per-slot valid bits), no clearing pass
// back-pressure
//   a stalled rsp_ch holds its result; a search with a further match, or a
//   closing result, waits in place until the output register frees up
// ----------------------------------------------------------------------------
module hash_multimap_quadratic_probe_top import hmqp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hmqp_req_if.sink   req_ch,
   hmqp_rsp_if.source rsp_ch
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;
   logic        req_ready;

   // sequencer: owns the request handshake and all ordering
   hmqp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_ch.ready = req_ready;

   // datapath: slot store, probe addresses, count and the result register
   hmqp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_op    (req_ch.op),
      .req_key   (req_ch.key),
      .req_value (req_ch.value),
      .rsp       (rsp_ch)
   );

`ifndef SYNTHESIS
   // search never modifies the table
   a_no_write_in_search: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (sts.op != OP_SEARCH))
      else $error("slot write during search");

   // results only enter a free output register
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.pend_emit || cmd.final_push) |-> sts.out_free)
      else $error("result pushed into a busy output register");

   // a non-final search result exists only when a match is held
   a_emit_has_match: assert property (@(posedge clock) disable iff (reset)
      cmd.pend_emit |-> (sts.have_pend && sts.op == OP_SEARCH))
      else $error("search result sent without a held match");

   // the live count never exceeds the slot count
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.entry_total <= COUNT_W'(SLOTS)))
      else $error("entry count above table size");
`endif

endmodule
